>>> hdl/tks_pkg.sv
// Shared types and constants for the streaming top-k running-sum heap.
// Used by tks_front, tks_heap and top_k_running_sum_heap_core; no dependencies.
package tks_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned KeyWidth   = 31;
   localparam int unsigned SumWidth   = 42;
   localparam int unsigned PosWidth   = 32;
   localparam int unsigned PenWidth   = 31;
   localparam int unsigned KeepWidth  = 11;
   localparam int unsigned BestWidth  = 64;
   localparam int unsigned ScoreWidth = 63;
   localparam int unsigned CsrWidth   = 31;

   localparam logic CsrKeepCount = 1'b0;
   localparam logic CsrPenalty   = 1'b1;

   // Classified item handed from the front part to the back part.
   typedef struct packed {
      logic                restart;
      logic                positive;
      logic [KeyWidth-1:0] key;
   } job_type;

endpackage

>>> hdl/tks_front.sv
// Front part: accepts input items, classifies them and queues them.
// Depends on tks_pkg.
module tks_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [tks_pkg::ValueWidth-1:0] req_value,
   input  logic                       req_restart,
   output logic                       job_valid,
   input  logic                       job_take,
   output tks_pkg::job_type           job
);

   tks_pkg::job_type q_ff [2];
   tks_pkg::job_type in_job;
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   always_comb begin
      in_job.restart  = req_restart;
      in_job.positive = !req_value[tks_pkg::ValueWidth-1] && (req_value != '0);
      in_job.key      = req_value[tks_pkg::KeyWidth-1:0];
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_take;
   assign job       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= in_job;
      end
   end

endmodule

>>> hdl/tks_heap.sv
// Back part: min-heap in a memory, running sum, position and best score.
// Depends on tks_pkg.
module tks_heap #(
   parameter int unsigned MAX_KEEP = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tks_pkg::KeepWidth-1:0] keep_count,
   input  logic [tks_pkg::PenWidth-1:0]  penalty,
   input  logic                         job_valid,
   output logic                         job_take,
   input  tks_pkg::job_type             job,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tks_pkg::ScoreWidth-1:0] rsp_best_score,
   output logic [tks_pkg::SumWidth-1:0]   rsp_kept_sum
);

   localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int unsigned FW = $clog2(MAX_KEEP + 1);
   localparam int unsigned MW = tks_pkg::PenWidth + tks_pkg::PosWidth;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_UPRD   = 10'b0000000010,
      S_UPCMP  = 10'b0000000100,
      S_ROOTRD = 10'b0000001000,
      S_ROOTCK = 10'b0000010000,
      S_DNRDL  = 10'b0000100000,
      S_DNRDR  = 10'b0001000000,
      S_DNCMP  = 10'b0010000000,
      S_SCORE  = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [tks_pkg::KeyWidth-1:0] mem [MAX_KEEP];
   logic [tks_pkg::KeyWidth-1:0] rdata_ff;
   logic                         mem_we, mem_re;
   logic [AW-1:0]                mem_wa, mem_ra;
   logic [tks_pkg::KeyWidth-1:0] mem_wd;

   logic [FW-1:0]                   fill_ff, fill_in;
   logic [tks_pkg::SumWidth-1:0]    sum_ff, sum_in;
   logic [tks_pkg::PosWidth-1:0]    pos_ff, pos_in;
   logic signed [tks_pkg::BestWidth-1:0] best_ff, best_in;
   logic [tks_pkg::KeyWidth-1:0]    key_ff, key_in;
   logic [FW-1:0]                   idx_ff, idx_in;
   logic [tks_pkg::KeyWidth-1:0]    lval_ff, lval_in;
   logic                            has_l_ff, has_l_in, has_r_ff, has_r_in;
   logic [MW-1:0]                   prod_ff, prod_in;
   logic                            out_ff, out_in;
   logic [tks_pkg::ScoreWidth-1:0]  ob_ff, ob_in;
   logic [tks_pkg::SumWidth-1:0]    os_ff, os_in;

   logic [FW-1:0]   cap;
   logic [FW-1:0]   parent, left, right;
   logic [FW:0]     left_w;
   logic signed [tks_pkg::BestWidth-1:0] score;

   always_comb begin
      if (keep_count == '0) begin
         cap = FW'(1);
      end else if ({21'd0, keep_count} > 32'(MAX_KEEP)) begin
         cap = FW'(MAX_KEEP);
      end else begin
         cap = FW'(keep_count);
      end
      parent = (idx_ff - FW'(1)) >> 1;
      left_w = {idx_ff, 1'b1};
      left   = left_w[FW-1:0];
      right  = left + FW'(1);
      score  = $signed({22'd0, sum_ff}) - $signed({1'b0, prod_ff});
   end

   assign job_take       = (state_ff == S_IDLE) && !out_ff;
   assign rsp_valid      = out_ff;
   assign rsp_best_score = ob_ff;
   assign rsp_kept_sum   = os_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      best_in  = best_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      lval_in  = lval_ff;
      has_l_in = has_l_ff;
      has_r_in = has_r_ff;
      prod_in  = prod_ff;
      out_in   = out_ff && rsp_stall;
      ob_in    = ob_ff;
      os_in    = os_ff;
      mem_we   = 1'b0;
      mem_wa   = '0;
      mem_wd   = key_ff;
      mem_re   = 1'b0;
      mem_ra   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && !out_ff) begin
               // Restart clears before this item counts.
               if (job.restart) begin
                  fill_in = '0;
                  sum_in  = '0;
                  best_in = '1;
                  pos_in  = tks_pkg::PosWidth'(1);
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
               key_in = job.key;
               if (!job.positive) begin
                  state_in = S_OUT;
               end else if ((job.restart ? '0 : fill_ff) < cap) begin
                  // Append at the end and sift up.
                  idx_in = job.restart ? '0 : fill_ff;
                  fill_in = (job.restart ? '0 : fill_ff) + FW'(1);
                  sum_in = (job.restart ? '0 : sum_ff) + 42'(job.key);
                  state_in = S_UPRD;
               end else begin
                  mem_re   = 1'b1;
                  mem_ra   = '0;
                  state_in = S_ROOTCK;
               end
            end
         end
         S_UPRD: begin
            if (idx_ff == '0) begin
               mem_we = 1'b1;
               mem_wa = '0;
               state_in = S_SCORE;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = AW'(parent);
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            mem_we = 1'b1;
            mem_wa = AW'(idx_ff);
            if (key_ff >= rdata_ff) begin
               state_in = S_SCORE;
            end else begin
               mem_wd   = rdata_ff;
               idx_in   = parent;
               state_in = S_UPRD;
            end
         end
         S_ROOTCK: begin
            if (key_ff > rdata_ff) begin
               sum_in   = sum_ff + 42'(key_ff) - 42'(rdata_ff);
               idx_in   = '0;
               state_in = S_DNRDL;
            end else begin
               state_in = S_SCORE;
            end
         end
         S_DNRDL: begin
            has_l_in = {1'b0, left} < {1'b0, fill_ff} && left_w[FW] == 1'b0;
            has_r_in = {1'b0, right} < {1'b0, fill_ff} && left_w[FW] == 1'b0
                       && right != '0;
            if (has_l_in) begin
               mem_re   = 1'b1;
               mem_ra   = AW'(left);
               state_in = S_DNRDR;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = AW'(idx_ff);
               state_in = S_SCORE;
            end
         end
         S_DNRDR: begin
            lval_in = rdata_ff;
            mem_re  = 1'b1;
            mem_ra  = AW'(right);
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            mem_we = 1'b1;
            mem_wa = AW'(idx_ff);
            if (has_r_ff && rdata_ff < lval_ff && rdata_ff < key_ff) begin
               mem_wd   = rdata_ff;
               idx_in   = right;
               state_in = S_DNRDL;
            end else if (lval_ff < key_ff) begin
               mem_wd   = lval_ff;
               idx_in   = left;
               state_in = S_DNRDL;
            end else begin
               state_in = S_SCORE;
            end
         end
         S_ROOTRD: begin
            state_in = S_SCORE;
         end
         S_SCORE: begin
            prod_in  = MW'(penalty) * MW'(pos_ff);
            state_in = S_OUT;
            // Score is formed from the registered product in S_OUT.
            has_l_in = 1'b1;
         end
         S_OUT: begin
            if (has_l_ff && key_ff != '0 && score > best_ff) begin
               best_in = score;
            end
            has_l_in = 1'b0;
            if (!out_ff || !rsp_stall) begin
               out_in = 1'b1;
               if (has_l_ff && key_ff != '0 && score > best_ff) begin
                  ob_in = score[tks_pkg::ScoreWidth-1:0];
               end else begin
                  ob_in = best_ff[tks_pkg::BestWidth-1] ? '0
                        : best_ff[tks_pkg::ScoreWidth-1:0];
               end
               os_in    = sum_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         sum_ff   <= '0;
         pos_ff   <= '0;
         best_ff  <= '1;
         out_ff   <= 1'b0;
         has_l_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         best_ff  <= best_in;
         out_ff   <= out_in;
         has_l_ff <= has_l_in;
      end
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      lval_ff  <= lval_in;
      has_r_ff <= has_r_in;
      prod_ff  <= prod_in;
      ob_ff    <= ob_in;
      os_ff    <= os_in;
   end

endmodule

>>> hdl/top_k_running_sum_heap_core.sv
// Top level of the streaming top-k running-sum heap block.
// Depends on tks_pkg, tks_front and tks_heap.

// One item in, one result out. A nonpositive item goes straight to the result;
// a positive one is appended and sifted up while the heap is below its keep
// count, else it is dropped when it does not beat the heap minimum, or it
// replaces the root and is sifted down (single-port heap memory with
// registered read). A two-entry queue lets items arrive while the back part
// works, and the result register holds a finished result while the next item
// waits in the queue. Write keep_count and penalty only while the block is
// idle.
module top_k_running_sum_heap_core #(
   parameter int unsigned MAX_KEEP = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tks_pkg::ValueWidth-1:0]     req_value,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tks_pkg::ScoreWidth-1:0]     rsp_best_score,
   output logic [tks_pkg::SumWidth-1:0]       rsp_kept_sum,
   input  logic                               csr_write,
   input  logic                               csr_index,
   input  logic [tks_pkg::CsrWidth-1:0]       csr_data
);

   logic [tks_pkg::KeepWidth-1:0] keep_ff;
   logic [tks_pkg::PenWidth-1:0]  pen_ff;
   logic                          job_valid, job_take;
   tks_pkg::job_type              job;

   // Hold configuration registers; write only the addressed one.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= tks_pkg::KeepWidth'(1);
         pen_ff  <= '0;
      end else if (csr_write) begin
         if (csr_index == tks_pkg::CsrKeepCount) begin
            keep_ff <= csr_data[tks_pkg::KeepWidth-1:0];
         end else begin
            pen_ff <= csr_data[tks_pkg::PenWidth-1:0];
         end
      end
   end

   tks_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .req_restart(req_restart),
      .job_valid  (job_valid),
      .job_take   (job_take),
      .job        (job)
   );

   tks_heap #(.MAX_KEEP(MAX_KEEP)) u_heap (
      .clock         (clock),
      .reset         (reset),
      .keep_count    (keep_ff),
      .penalty       (pen_ff),
      .job_valid     (job_valid),
      .job_take      (job_take),
      .job           (job),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_best_score(rsp_best_score),
      .rsp_kept_sum  (rsp_kept_sum)
   );

   // Handshake outputs are always known out of reset.
   a_ctrl_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_stall, rsp_valid}))
      else $error("handshake output unknown");

   // A result is held while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      rsp_valid && $stable(rsp_kept_sum) && $stable(rsp_best_score))
      else $error("result dropped under stall");

endmodule

>>> bench/tb.sv
// Testbench for top_k_running_sum_heap_core: drives random and directed values,
// predicts best score and kept sum with a local heap model. Depends on tks_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned MaxKeep = 1024;
   localparam int unsigned CycleLimit = 2000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [tks_pkg::ValueWidth-1:0] req_value = '0;
   logic                           req_restart = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [tks_pkg::ScoreWidth-1:0] rsp_best_score;
   logic [tks_pkg::SumWidth-1:0]   rsp_kept_sum;
   logic                           csr_write = 1'b0;
   logic                           csr_index = tks_pkg::CsrKeepCount;
   logic [tks_pkg::CsrWidth-1:0]   csr_data = '0;

   top_k_running_sum_heap_core #(.MAX_KEEP(MaxKeep)) DUT (.*);

   always #2 clock = ~clock;

   // Expected result of one item.
   typedef struct packed {
      logic [tks_pkg::ScoreWidth-1:0] best;
      logic [tks_pkg::SumWidth-1:0]   sum;
   } outcome_type;

   outcome_type pending_outcomes[$];

   // Local copy of the block state.
   logic [tks_pkg::KeyWidth-1:0]  kept_keys[MaxKeep];
   int unsigned                   fill_count;
   logic [tks_pkg::SumWidth-1:0]  kept_total;
   logic [tks_pkg::PosWidth-1:0]  stream_pos;
   logic signed [63:0]            top_score;
   logic [tks_pkg::KeepWidth-1:0] keep_reg;
   logic [tks_pkg::PenWidth-1:0]  penalty_reg;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          idle_pct = 17;
   bit          hold_off = 1'b0;

   task automatic clear_tally();
      fill_count = 0;
      kept_total = '0;
      stream_pos = '0;
      top_score  = -64'sd1;
   endtask

   // Advance the heap model by one value and queue the expected result.
   task automatic predict_outcome(input logic [tks_pkg::ValueWidth-1:0] value,
                                  input logic restart);
      int unsigned cap;
      int unsigned i;
      int unsigned parent;
      int unsigned lo;
      logic [tks_pkg::KeyWidth-1:0] t;
      logic signed [63:0] score;
      outcome_type o;
      cap = (keep_reg == 0) ? 1 : ((keep_reg > MaxKeep) ? MaxKeep : keep_reg);
      if (restart) clear_tally();
      stream_pos = stream_pos + 1;
      if (!value[31] && value != 0) begin
         if (fill_count < cap) begin
            kept_keys[fill_count] = value[30:0];
            i = fill_count;
            while (i > 0) begin
               parent = (i - 1) / 2;
               if (kept_keys[i] >= kept_keys[parent]) break;
               t = kept_keys[i]; kept_keys[i] = kept_keys[parent]; kept_keys[parent] = t;
               i = parent;
            end
            fill_count++;
            kept_total = kept_total + value[30:0];
         end else if (value[30:0] > kept_keys[0]) begin
            kept_total = kept_total + value[30:0] - kept_keys[0];
            kept_keys[0] = value[30:0];
            i = 0;
            forever begin
               lo = i;
               if (2*i+1 < fill_count && kept_keys[2*i+1] < kept_keys[lo]) lo = 2*i+1;
               if (2*i+2 < fill_count && kept_keys[2*i+2] < kept_keys[lo]) lo = 2*i+2;
               if (lo == i) break;
               t = kept_keys[i]; kept_keys[i] = kept_keys[lo]; kept_keys[lo] = t;
               i = lo;
            end
         end
         score = $signed({22'd0, kept_total}) - $signed(64'(penalty_reg) * 64'(stream_pos));
         if (score > top_score) top_score = score;
      end
      o.best = (top_score > 0) ? top_score[tks_pkg::ScoreWidth-1:0] : '0;
      o.sum  = kept_total;
      pending_outcomes.push_back(o);
   endtask

   // Idle at random, offer one item and hold it until accepted.
   task automatic send_item(input logic [tks_pkg::ValueWidth-1:0] value,
                            input logic restart);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= value;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_outcome(value, restart);
   endtask

   // Drop valid after the last item of a sequence.
   task automatic end_items();
      req_valid <= 1'b0;
   endtask

   // Wait until every result is back, plus the back part's tail.
   task automatic wait_drained();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [tks_pkg::CsrWidth-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == tks_pkg::CsrKeepCount) keep_reg = data[tks_pkg::KeepWidth-1:0];
      else penalty_reg = data[tks_pkg::PenWidth-1:0];
      @(posedge clock);
   endtask

   function automatic logic [tks_pkg::ValueWidth-1:0] random_value();
      case ($urandom_range(9))
         0: return $urandom;
         1: return {1'b1, 31'($urandom)};
         2: return '0;
         3: return 32'h7FFF_FFFF - $urandom_range(3);
         4: return $urandom_range(5) + 1;
         default: return {1'b0, 31'($urandom)} >> $urandom_range(30);
      endcase
   endfunction

   // Receiver: random stalls, or a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < idle_pct);
      end
   end

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result best=%0d sum=%0d",
                                               rsp_best_score, rsp_kept_sum);
         end else begin
            exp_o = pending_outcomes.pop_front();
            if (exp_o.best !== rsp_best_score || exp_o.sum !== rsp_kept_sum) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected best=%0d sum=%0d, got best=%0d sum=%0d",
                           exp_o.best, exp_o.sum, rsp_best_score, rsp_kept_sum);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("top_k_running_sum_heap_core test failed");
         $finish;
      end
   end

   // Extremes, zero, negatives, restart, non-improving values.
   task automatic test_directed();
      write_csr(tks_pkg::CsrKeepCount, 31'd3);
      write_csr(tks_pkg::CsrPenalty, 31'd0);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item('0, 1'b0);
      send_item(1, 1'b0);
      send_item(2, 1'b0);
      send_item(1, 1'b0);   // equals minimum of full heap
      send_item(32'h7FFF_FFFE, 1'b0);
      send_item(5, 1'b1);   // restart
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b0);
      end_items();
      wait_drained();
      // Penalty dominates: best stays floored at zero.
      write_csr(tks_pkg::CsrPenalty, 31'h7FFF_FFFF);
      send_item(7, 1'b1);
      send_item(9, 1'b0);
      end_items();
      wait_drained();
      // Keep count zero behaves as one; lowering below fill keeps entries.
      write_csr(tks_pkg::CsrKeepCount, 31'd0);
      write_csr(tks_pkg::CsrPenalty, 31'd1);
      send_item(100, 1'b0);
      send_item(200, 1'b0);
      end_items();
      wait_drained();
      write_csr(tks_pkg::CsrKeepCount, 31'h7FF);
      send_item(3, 1'b0);
      send_item(300, 1'b0);
      end_items();
      wait_drained();
   endtask

   // Random values under a given configuration, restarts now and then.
   task automatic test_random(input int count, input logic [tks_pkg::KeepWidth-1:0] keep,
                              input logic [tks_pkg::PenWidth-1:0] pen);
      write_csr(tks_pkg::CsrKeepCount, tks_pkg::CsrWidth'(keep));
      write_csr(tks_pkg::CsrPenalty, tks_pkg::CsrWidth'(pen));
      for (int n = 0; n < count; n++)
         send_item(random_value(), ($urandom_range(99) < 3) || n == 0);
      end_items();
      wait_drained();
   endtask

   // Receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int n = 0; n < 30; n++) send_item(random_value(), 1'b0);
            end_items();
         end
      join
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      keep_reg = tks_pkg::KeepWidth'(1);
      penalty_reg = '0;
      clear_tally();
      test_directed();
      test_random(250, 11'd4, tks_pkg::PenWidth'($urandom_range(1000)));
      test_random(250, 11'd1024, tks_pkg::PenWidth'($urandom_range(3)));
      idle_pct = 0;   // stretch with no idling
      test_random(200, 11'd16, tks_pkg::PenWidth'($urandom));
      idle_pct = 17;
      test_backpressure();
      test_random(250, 11'd1100, 31'd0);
      test_random(250, tks_pkg::KeepWidth'($urandom_range(1, 64)),
                  tks_pkg::PenWidth'($urandom_range(1 << 20)));
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("top_k_running_sum_heap_core test passed");
      else
         $display("top_k_running_sum_heap_core test failed");
      $finish;
   end

endmodule
